// File: design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared constants and character helpers
// Character codes and precedence/class functions for the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;

  localparam char_t CH_0 = 8'h30;
  localparam char_t CH_9 = 8'h39;
  localparam char_t CH_A = 8'h41;
  localparam char_t CH_Z = 8'h5A;
  localparam char_t CH_LA = 8'h61;
  localparam char_t CH_LZ = 8'h7A;

  typedef logic [1:0] prec_t;

  function automatic prec_t prec_of(input char_t c);
    prec_t p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end
    return p;
  endfunction

  function automatic logic is_alnum(input char_t c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_Z) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

endpackage

`default_nettype wire

// File: design/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack: operator stack storage
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_stack
  import itp_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire char_t             wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output char_t                  rdata
);

  char_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix
// Takes one expression character per transfer, keeps an operator stack in
// memory and emits the postfix characters one per output transfer.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_stall | char_in[7:0], end_mark
//  out     | out_valid/out_stall | char_out[7:0], last_of_run, from_flush
//
//  Letter/digit: IDLE, then ALNUM. '(' and a flush of an empty stack are
//  handled in IDLE. Other items: IDLE, then READ (memory read) and TEST
//  (compare in the sequencer) per stack entry examined, then FINISH; the
//  entry that stops the popping is examined too. The registered read data
//  of the stack memory is why READ precedes TEST. A result may wait in the
//  output register while the next item is taken. Output stalls hold the
//  sequencer where it must hand over a character. Synchronous reset empties
//  the stack and stalls the input; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       end_mark,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      char_out,
  output logic            last_of_run,
  output logic            from_flush
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALNUM  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_TEST   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [1:0] M_FLUSH  = 2'd0;
  localparam logic [1:0] M_RPAREN = 2'd1;
  localparam logic [1:0] M_OP     = 2'd2;

  logic [2:0]       state;
  logic [1:0]       mode;
  char_t            cur;
  logic [CNT_W-1:0] stack_count;
  logic             pend_valid;
  char_t            pend_char;

  logic             out_free;
  logic             stk_full;
  logic [CNT_W-1:0] top_idx;
  logic             stk_we;
  logic             stk_re;
  char_t            top_data;
  logic             in_xfer;
  logic             do_pop;

  assign in_stall = rst || (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign stk_full = (stack_count == CNT_W'(STACK_DEPTH));
  assign top_idx  = stack_count - CNT_W'(1);
  assign stk_re   = (state == S_READ);

  // push happens for '(' at accept, or for an operator at finish
  always_comb begin
    stk_we = 1'b0;
    if (!stk_full) begin
      if (in_xfer && !end_mark && char_in == CH_LPAREN) begin
        stk_we = 1'b1;
      end else if (state == S_FINISH && mode == M_OP && (!pend_valid || out_free)) begin
        stk_we = 1'b1;
      end
    end
  end

  itp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_count[ADDR_W-1:0]),
    .wdata (in_xfer ? char_t'(char_in) : cur),
    .re    (stk_re),
    .raddr (top_idx[ADDR_W-1:0]),
    .rdata (top_data)
  );

  always_comb begin
    case (mode)
      M_FLUSH:  do_pop = 1'b1;
      M_RPAREN: do_pop = (top_data != CH_LPAREN);
      M_OP:     do_pop = (prec_of(cur) <= prec_of(top_data));
      default:  do_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_count <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (stk_we) begin
        stack_count <= stack_count + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cur <= char_in;
            if (end_mark) begin
              mode <= M_FLUSH;
              if (stack_count != '0) begin
                state <= S_READ;
              end
            end else if (is_alnum(char_in)) begin
              state <= S_ALNUM;
            end else if (char_in != CH_LPAREN) begin
              mode  <= (char_in == CH_RPAREN) ? M_RPAREN : M_OP;
              state <= (stack_count != '0) ? S_READ : S_FINISH;
            end
          end
        end
        S_ALNUM: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            char_out    <= cur;
            last_of_run <= 1'b1;
            from_flush  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_TEST;
        end
        S_TEST: begin
          if (!do_pop) begin
            if (mode == M_RPAREN) begin
              stack_count <= top_idx;   // drop the matching '('
            end
            state <= S_FINISH;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid   <= 1'b1;
              char_out    <= pend_char;
              last_of_run <= 1'b0;
              from_flush  <= (mode == M_FLUSH);
            end
            pend_valid  <= 1'b1;
            pend_char   <= top_data;
            stack_count <= top_idx;
            state       <= (top_idx != '0) ? S_READ : S_FINISH;
          end
        end
        S_FINISH: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid   <= 1'b1;
              char_out    <= pend_char;
              last_of_run <= 1'b1;
              from_flush  <= (mode == M_FLUSH);
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
